[hw/rtl/mwcf_pkg.sv]
// ----------------------------------------------------------------------------
// mwcf_pkg
// Shared types and constants for the minimum covering window finder.
// ----------------------------------------------------------------------------
package mwcf_pkg;

  // Fixed field widths of the item and result channels
  localparam int KIND_W  = 2;
  localparam int CH_W    = 8;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // Required counts and the pattern length share this width
  localparam int NEED_W      = 13;
  localparam int PATTERN_MAX = 8191;

  // Parameter defaults
  localparam int TEXT_DEPTH_DEF    = 4096;
  localparam int ALPHABET_SIZE_DEF = 256;

  typedef logic [KIND_W-1:0] kind_t;

  // Item kinds
  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_PAT   = 2'd1;
  localparam kind_t KIND_TEXT  = 2'd2;

endpackage

[hw/rtl/mwcf_cnt_tbl.sv]
// ----------------------------------------------------------------------------
// mwcf_cnt_tbl
// Per-character count table: required count and window count in one entry,
// one read port with a registered result, one write port, valid bits.
// ----------------------------------------------------------------------------
module mwcf_cnt_tbl #(
  parameter int ALPHABET_SIZE = mwcf_pkg::ALPHABET_SIZE_DEF,
  parameter int WIN_W         = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             rd_en,
  input  logic [$clog2(ALPHABET_SIZE)-1:0] rd_addr,
  input  logic                             wr_en,
  input  logic [$clog2(ALPHABET_SIZE)-1:0] wr_addr,
  input  logic [mwcf_pkg::NEED_W-1:0]      wr_need,
  input  logic [WIN_W-1:0]                 wr_win,
  output logic [mwcf_pkg::NEED_W-1:0]      rd_need,
  output logic [WIN_W-1:0]                 rd_win
);

  localparam int ENT_W = mwcf_pkg::NEED_W + WIN_W;

  logic [ENT_W-1:0]         mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;
  logic [ENT_W-1:0]         rd_q_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_need, wr_win};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_need = rd_vld_r ? rd_q_r[ENT_W-1:WIN_W] : '0;
  assign rd_win  = rd_vld_r ? rd_q_r[WIN_W-1:0]     : '0;

endmodule

[hw/rtl/min_window_cover_finder.sv]
// ----------------------------------------------------------------------------
// min_window_cover_finder
// Streams a pattern, then text, and tracks the shortest text window that holds
// every pattern character with its multiplicity. A start item clears the
// query; pattern items fill the required-count table (ignored once text has
// begun or at PATTERN_MAX); every text item returns one result: found, best
// start, best length and overflow (text beyond TEXT_DEPTH is dropped and
// flagged). Ties keep the earliest window. Items are taken one at a time. A
// pattern item reads, then writes its count; a text item updates its window
// count unless it overflows, and one that completes a cover then shrinks the
// left edge, each step a text buffer read followed by a count table read, both
// registered. Left-edge steps are bounded by the text length, so they amortize
// to about one per text item. The count table clears at once through valid
// bits, so no clearing pass follows reset or a start item. A finished result
// sits in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module min_window_cover_finder #(
  parameter int TEXT_DEPTH    = mwcf_pkg::TEXT_DEPTH_DEF,
  parameter int ALPHABET_SIZE = mwcf_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mwcf_pkg::KIND_W-1:0] in_kind,
  input  logic [mwcf_pkg::CH_W-1:0]   in_ch,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [mwcf_pkg::START_W-1:0] out_best_start,
  output logic [mwcf_pkg::LEN_W-1:0]  out_best_length,
  output logic                        out_overflow
);

  localparam int AW = $clog2(TEXT_DEPTH);       // text address
  localparam int PW = $clog2(TEXT_DEPTH + 1);   // text position / length
  localparam int XW = $clog2(ALPHABET_SIZE);    // character index
  localparam int NW = mwcf_pkg::NEED_W;
  localparam int CW = (PW > NW) ? PW : NW;      // count compare width
  localparam int NCH = 2 ** mwcf_pkg::CH_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take an item
  localparam logic [2:0] S_PAT  = 3'd1;  // bump required count
  localparam logic [2:0] S_TXT  = 3'd2;  // bump window count, check cover
  localparam logic [2:0] S_TRD  = 3'd3;  // left byte back, read its counts
  localparam logic [2:0] S_LCK  = 3'd4;  // decide: drop left byte or stop
  localparam logic [2:0] S_FIN  = 3'd5;  // final window check, emit result

  // Character folding into the alphabet, one entry per byte value
  logic [XW-1:0] ch_mod [NCH];
  for (genvar g = 0; g < NCH; g++) begin : g_mod
    assign ch_mod[g] = XW'(g % ALPHABET_SIZE);
  end

  logic [XW-1:0] in_idx;
  assign in_idx = ch_mod[in_ch];

  // ---------------------------------------------------------------- state
  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] pat_len_r, pat_len_nxt;
  logic [NW-1:0] matched_r, matched_nxt;
  logic [PW-1:0] text_pos_r, text_pos_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic [AW-1:0] best_pos_r, best_pos_nxt;
  logic [PW-1:0] best_len_r, best_len_nxt;
  logic          have_r, have_nxt;
  logic [XW-1:0] c_r, c_nxt;         // character of the current text/pattern item
  logic [XW-1:0] lc_r, lc_nxt;       // character at the left edge
  logic          cover_r, cover_nxt;
  logic          ovf_r, ovf_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [mwcf_pkg::START_W-1:0] out_start_r, out_start_nxt;
  logic [mwcf_pkg::LEN_W-1:0]   out_len_r, out_len_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // --------------------------------------------------------- text buffer
  logic [mwcf_pkg::CH_W-1:0] text_mem [TEXT_DEPTH];
  logic [mwcf_pkg::CH_W-1:0] txt_q_r;
  logic                      txt_we, txt_re;
  logic [AW-1:0]             txt_raddr;

  always_ff @(posedge clk) begin
    if (txt_we) begin
      text_mem[text_pos_r[AW-1:0]] <= mwcf_pkg::CH_W'(in_idx);
    end
    if (txt_re) begin
      txt_q_r <= text_mem[txt_raddr];
    end
  end

  // --------------------------------------------------------- count table
  logic          cnt_clr, cnt_re, cnt_we;
  logic [XW-1:0] cnt_raddr, cnt_waddr;
  logic [NW-1:0] cnt_wneed, rd_need;
  logic [PW-1:0] cnt_wwin, rd_win;

  // Reads and writes of the count table always fall in different cycles, and
  // every read comes after the write it depends on, so no forwarding is needed.
  mwcf_cnt_tbl #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .WIN_W         (PW)
  ) u_cnt_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cnt_clr),
    .rd_en   (cnt_re),
    .rd_addr (cnt_raddr),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_need (cnt_wneed),
    .wr_win  (cnt_wwin),
    .rd_need (rd_need),
    .rd_win  (rd_win)
  );

  // ------------------------------------------------------------ datapath
  logic          acc;
  logic          out_free;
  logic [PW-1:0] win_inc;
  logic          hit;
  logic          brk;
  logic [PW-1:0] cons_len;
  logic          cons_take;
  logic [AW-1:0] right;
  logic [AW-1:0] left_inc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign right    = text_pos_r[AW-1:0];
  assign left_inc = left_r + AW'(1);
  assign win_inc  = rd_win + PW'(1);

  // New text byte still within its requirement counts toward the match
  assign hit = (rd_need != '0) && (CW'(win_inc) <= CW'(rd_need));

  // Left byte that is required and not in surplus stops the shrink
  assign brk = (rd_need != '0) && (CW'(rd_win) <= CW'(rd_need));

  // Window ending at the current text byte from the current left edge
  assign cons_len  = text_pos_r - PW'(left_r) + PW'(1);
  assign cons_take = !have_r || (cons_len < best_len_r);

  always_comb begin
    state_nxt    = state_r;
    pat_len_nxt  = pat_len_r;
    matched_nxt  = matched_r;
    text_pos_nxt = text_pos_r;
    left_nxt     = left_r;
    best_pos_nxt = best_pos_r;
    best_len_nxt = best_len_r;
    have_nxt     = have_r;
    c_nxt        = c_r;
    lc_nxt       = lc_r;
    cover_nxt    = cover_r;
    ovf_nxt      = ovf_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;

    txt_we    = 1'b0;
    txt_re    = 1'b0;
    txt_raddr = left_r;
    cnt_clr   = 1'b0;
    cnt_re    = 1'b0;
    cnt_raddr = in_idx;
    cnt_we    = 1'b0;
    cnt_waddr = c_r;
    cnt_wneed = rd_need;
    cnt_wwin  = rd_win;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            mwcf_pkg::KIND_START: begin
              cnt_clr      = 1'b1;
              pat_len_nxt  = '0;
              matched_nxt  = '0;
              text_pos_nxt = '0;
              left_nxt     = '0;
              best_pos_nxt = '0;
              best_len_nxt = '0;
              have_nxt     = 1'b0;
            end
            mwcf_pkg::KIND_PAT: begin
              // Pattern bytes count only before text and up to the length limit
              if (text_pos_r == '0 && pat_len_r < NW'(mwcf_pkg::PATTERN_MAX)) begin
                cnt_re    = 1'b1;
                c_nxt     = in_idx;
                state_nxt = S_PAT;
              end
            end
            mwcf_pkg::KIND_TEXT: begin
              c_nxt     = in_idx;
              cover_nxt = 1'b0;
              if (text_pos_r >= PW'(TEXT_DEPTH)) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_FIN;
              end else begin
                ovf_nxt   = 1'b0;
                txt_we    = 1'b1;
                cnt_re    = 1'b1;
                state_nxt = S_TXT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PAT: begin
        cnt_we      = 1'b1;
        cnt_wneed   = rd_need + NW'(1);
        pat_len_nxt = pat_len_r + NW'(1);
        state_nxt   = S_IDLE;
      end

      S_TXT: begin
        cnt_we   = 1'b1;
        cnt_wwin = win_inc;
        if (hit) begin
          matched_nxt = matched_r + NW'(1);
        end
        if (pat_len_r != '0 && matched_nxt == pat_len_r) begin
          // Covered: record this window, then try to shrink from the left
          cover_nxt = 1'b1;
          if (cons_take) begin
            have_nxt     = 1'b1;
            best_len_nxt = cons_len;
            best_pos_nxt = left_r;
          end
          if (left_r < right) begin
            txt_re    = 1'b1;
            txt_raddr = left_r;
            state_nxt = S_TRD;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (out_free) begin
          // Nothing changes in the best window: emit right away
          out_valid_nxt = 1'b1;
          out_found_nxt = have_r;
          out_start_nxt = mwcf_pkg::START_W'(best_pos_r);
          out_len_nxt   = mwcf_pkg::LEN_W'(best_len_r);
          out_ovf_nxt   = 1'b0;
          text_pos_nxt  = text_pos_r + PW'(1);
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_TRD: begin
        cnt_re    = 1'b1;
        cnt_raddr = txt_q_r[XW-1:0];
        lc_nxt    = txt_q_r[XW-1:0];
        state_nxt = S_LCK;
      end

      S_LCK: begin
        if (brk) begin
          state_nxt = S_FIN;
        end else begin
          // Drop the left byte from the window and advance
          cnt_we    = 1'b1;
          cnt_waddr = lc_r;
          cnt_wwin  = rd_win - PW'(1);
          left_nxt  = left_inc;
          if (left_inc < right) begin
            txt_re    = 1'b1;
            txt_raddr = left_inc;
            state_nxt = S_TRD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          if (cover_r && cons_take) begin
            have_nxt     = 1'b1;
            best_len_nxt = cons_len;
            best_pos_nxt = left_r;
          end
          out_valid_nxt = 1'b1;
          out_found_nxt = have_nxt;
          out_start_nxt = mwcf_pkg::START_W'(best_pos_nxt);
          out_len_nxt   = mwcf_pkg::LEN_W'(best_len_nxt);
          out_ovf_nxt   = ovf_r;
          if (!ovf_r) begin
            text_pos_nxt = text_pos_r + PW'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pat_len_r   <= '0;
      matched_r   <= '0;
      text_pos_r  <= '0;
      left_r      <= '0;
      best_pos_r  <= '0;
      best_len_r  <= '0;
      have_r      <= 1'b0;
      cover_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_len_r   <= pat_len_nxt;
      matched_r   <= matched_nxt;
      text_pos_r  <= text_pos_nxt;
      left_r      <= left_nxt;
      best_pos_r  <= best_pos_nxt;
      best_len_r  <= best_len_nxt;
      have_r      <= have_nxt;
      cover_r     <= cover_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_r         <= c_nxt;
    lc_r        <= lc_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_best_start  = out_start_r;
  assign out_best_length = out_len_r;
  assign out_overflow    = out_ovf_r;

  // ---------------------------------------------------------- assertions
  // Shrinking never reaches the right edge
  a_left_below_right: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRD || state_r == S_LCK) |-> (PW'(left_r) < text_pos_r))
    else $error("left edge reached right edge during shrink");

  // Matched bytes never exceed the pattern length
  a_matched_bound: assert property (@(posedge clk) disable iff (!rst_n)
    matched_r <= pat_len_r)
    else $error("matched total exceeds pattern length");

  // A recorded window has a nonzero length
  a_best_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (best_len_r != '0))
    else $error("window found with zero length");

  // A new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_len_r)
      && $stable(out_start_r)))
    else $error("pending result overwritten");

endmodule
